/* rtl/ilp_pkg.sv */
`default_nettype none

package ilp_pkg;

   localparam int unsigned CharWidth   = 8;
   localparam int unsigned WordWidth   = 64;
   localparam int unsigned AccWidth    = 2 * WordWidth;
   localparam int unsigned DigitWidth  = 4;
   localparam int unsigned StatusWidth = 2;
   localparam int unsigned NullLength  = 7;
   localparam int unsigned QueueDepth  = 2;

   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_OCT = 2'd1,
      RADIX_HEX = 2'd2
   } radix_type;

   typedef enum logic [StatusWidth-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_DIGIT = 2'd1,
      STATUS_LONE_SIGN = 2'd2
   } status_type;

   // One classified character, handed from the front end to the accumulator.
   typedef struct packed {
      logic                  acc_en;
      radix_type             radix;
      logic [DigitWidth-1:0] digit;
      logic                  last;
      logic                  zero_out;
      logic                  negate;
      status_type            status;
   } cmd_type;

   // Characters of the keyword that parses as zero, by position.
   function automatic logic [CharWidth-1:0] null_char(input logic [2:0] pos);
      logic [CharWidth-1:0] ch;
      unique case (pos)
         3'd0: ch = "n";
         3'd1: ch = "u";
         3'd2: ch = "l";
         3'd3: ch = "l";
         3'd4: ch = "p";
         3'd5: ch = "t";
         3'd6: ch = "r";
         default: ch = 8'hFF;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

/* rtl/ilp_front.sv */
`default_nettype none

module ilp_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          take,
   input  wire logic [ilp_pkg::CharWidth-1:0] char_code,
   input  wire logic                          last_char,
   output ilp_pkg::cmd_type                   cmd
);
   import ilp_pkg::*;

   typedef enum logic [2:0] {
      PH_START  = 3'd0,
      PH_SIGN   = 3'd1,
      PH_ZERO   = 3'd2,
      PH_DIGITS = 3'd3,
      PH_HEX0   = 3'd4
   } phase_type;

   phase_type  phase_ff, phase_in;
   radix_type  radix_ff, radix_in;
   status_type err_ff, err_in;
   logic       neg_ff, neg_in;
   logic [2:0] pos_ff, pos_in;
   logic       alive_ff, alive_in;

   logic                  is_digit;
   logic [DigitWidth-1:0] dval;
   logic                  digit_ok;
   logic                  take_digit;
   radix_type             radix_eff;
   logic                  null_ok;
   logic                  acc_en;

   always_comb begin
      is_digit = 1'b1;
      dval     = '0;
      if (char_code >= "0" && char_code <= "9") begin
         dval = DigitWidth'(char_code - "0");
      end else if (char_code >= "a" && char_code <= "f") begin
         dval = DigitWidth'(char_code - "a" + 8'd10);
      end else if (char_code >= "A" && char_code <= "F") begin
         dval = DigitWidth'(char_code - "A" + 8'd10);
      end else begin
         is_digit = 1'b0;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      radix_in   = radix_ff;
      err_in     = err_ff;
      neg_in     = neg_ff;
      radix_eff  = radix_ff;
      take_digit = 1'b0;
      acc_en     = 1'b0;

      if (alive_ff && pos_ff < 3'(NullLength) && char_code == null_char(pos_ff)) begin
         pos_in   = pos_ff + 3'd1;
         alive_in = alive_ff;
      end else begin
         pos_in   = pos_ff;
         alive_in = 1'b0;
      end

      unique case (phase_ff)
         PH_ZERO: begin
            if (char_code == "x" || char_code == "X") begin
               radix_in = RADIX_HEX;
               phase_in = PH_HEX0;
            end else begin
               radix_in   = RADIX_OCT;
               radix_eff  = RADIX_OCT;
               take_digit = 1'b1;
               phase_in   = PH_DIGITS;
            end
         end
         PH_DIGITS, PH_HEX0: begin
            take_digit = 1'b1;
            phase_in   = PH_DIGITS;
         end
         PH_SIGN: begin
            if (char_code == "0") begin
               phase_in = PH_ZERO;
            end else begin
               take_digit = 1'b1;
               phase_in   = PH_DIGITS;
            end
         end
         default: begin
            if (char_code == "+" || char_code == "-") begin
               neg_in   = (char_code == "-");
               phase_in = PH_SIGN;
               if (last_char) begin
                  err_in = STATUS_LONE_SIGN;
               end
            end else if (char_code == "0") begin
               phase_in = PH_ZERO;
            end else begin
               take_digit = 1'b1;
               phase_in   = PH_DIGITS;
            end
         end
      endcase

      unique case (radix_eff)
         RADIX_HEX: digit_ok = is_digit;
         RADIX_OCT: digit_ok = is_digit && dval < DigitWidth'(8);
         default:   digit_ok = is_digit && dval < DigitWidth'(10);
      endcase

      if (take_digit && err_ff == STATUS_OK) begin
         if (digit_ok) begin
            acc_en = 1'b1;
         end else begin
            err_in = STATUS_BAD_DIGIT;
         end
      end

      null_ok = alive_in && pos_in == 3'(NullLength);

      cmd.acc_en   = acc_en;
      cmd.radix    = radix_eff;
      cmd.digit    = dval;
      cmd.last     = last_char;
      cmd.zero_out = null_ok || err_in != STATUS_OK;
      cmd.negate   = neg_in && !(null_ok || err_in != STATUS_OK);
      cmd.status   = null_ok ? STATUS_OK : err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         radix_ff <= RADIX_DEC;
         err_ff   <= STATUS_OK;
         neg_ff   <= 1'b0;
         pos_ff   <= '0;
         alive_ff <= 1'b1;
      end else if (take) begin
         if (last_char) begin
            // Every literal starts from a clean state.
            phase_ff <= PH_START;
            radix_ff <= RADIX_DEC;
            err_ff   <= STATUS_OK;
            neg_ff   <= 1'b0;
            pos_ff   <= '0;
            alive_ff <= 1'b1;
         end else begin
            phase_ff <= phase_in;
            radix_ff <= radix_in;
            err_ff   <= err_in;
            neg_ff   <= neg_in;
            pos_ff   <= pos_in;
            alive_ff <= alive_in;
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/ilp_queue.sv */
`default_nettype none

module ilp_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire ilp_pkg::cmd_type push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  head_valid,
   output ilp_pkg::cmd_type      head_data
);
   import ilp_pkg::*;

   localparam int unsigned PtrWidth = $clog2(QueueDepth);

   cmd_type               slot_ff [QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff;
   logic [PtrWidth-1:0]   rd_ptr_ff;
   logic [PtrWidth:0]     count_ff;

   assign full       = count_ff == (PtrWidth+1)'(QueueDepth);
   assign head_valid = count_ff != '0;
   assign head_data  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PtrWidth'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PtrWidth'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + (PtrWidth+1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (PtrWidth+1)'(1);
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/ilp_back.sv */
`default_nettype none

module ilp_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          head_valid,
   input  wire ilp_pkg::cmd_type              head_data,
   output logic                               pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [ilp_pkg::WordWidth-1:0]      rsp_value_low,
   output logic [ilp_pkg::WordWidth-1:0]      rsp_value_high,
   output logic [ilp_pkg::StatusWidth-1:0]    rsp_status
);
   import ilp_pkg::*;

   logic [AccWidth-1:0] acc_ff;
   logic [AccWidth-1:0] acc_in;
   logic [AccWidth-1:0] term_a;
   logic [AccWidth-1:0] term_b;

   logic                fin_valid_ff;
   logic [AccWidth-1:0] fin_value_ff;
   logic                fin_negate_ff;
   status_type          fin_status_ff;

   logic                out_valid_ff;
   logic [AccWidth-1:0] out_value_ff;
   status_type          out_status_ff;

   logic out_free;
   logic fin_free;
   logic fin_move;

   assign out_free = !out_valid_ff || rsp_ready;
   assign fin_move = fin_valid_ff && out_free;
   assign fin_free = !fin_valid_ff || out_free;
   // Only the last character of a literal needs room in the finish stage.
   assign pop      = head_valid && (!head_data.last || fin_free);

   // Base multiply as shifts: 16 = 1<<4, 8 = 1<<3, 10 = (1<<3) + (1<<1).
   always_comb begin
      unique case (head_data.radix)
         RADIX_HEX: begin
            term_a = acc_ff << 4;
            term_b = '0;
         end
         RADIX_OCT: begin
            term_a = acc_ff << 3;
            term_b = '0;
         end
         default: begin
            term_a = acc_ff << 3;
            term_b = acc_ff << 1;
         end
      endcase
      if (head_data.acc_en) begin
         acc_in = term_a + term_b + AccWidth'(head_data.digit);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         fin_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            acc_ff <= head_data.last ? '0 : acc_in;
         end

         if (pop && head_data.last) begin
            fin_valid_ff <= 1'b1;
         end else if (fin_move) begin
            fin_valid_ff <= 1'b0;
         end

         if (fin_move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head_data.last) begin
         fin_value_ff  <= head_data.zero_out ? '0 : acc_in;
         fin_negate_ff <= head_data.negate;
         fin_status_ff <= head_data.status;
      end
      if (fin_move) begin
         out_value_ff  <= fin_negate_ff ? (~fin_value_ff + AccWidth'(1)) : fin_value_ff;
         out_status_ff <= fin_status_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_value_low  = out_value_ff[WordWidth-1:0];
   assign rsp_value_high = out_value_ff[AccWidth-1:WordWidth];
   assign rsp_status     = out_status_ff;

endmodule

`default_nettype wire

/* rtl/int128_literal_parser_core.sv */
// Integer literal parser with a 128-bit two's-complement result.
// The req channel carries one character per item (req_char_code) and a
// req_last_char mark on the final character of a literal. A literal may
// start with a sign, then 0x/0X for hex or a leading 0 for octal; the exact
// text "nullptr" also parses as zero. Only the last character of a literal
// produces an item on the rsp channel: the value split into two 64-bit words
// and a status (ok, invalid digit for the base, sign without digits). On an
// error the value is zero.
// One character is accepted per cycle when nothing stalls. The front end
// tracks phase, base, sign and the keyword match and pushes one command per
// character into a two-entry queue; the back end does one 128-bit
// multiply-by-base-and-add per cycle while it may pop. A literal's last
// character passes through the queue, the finish stage and the negate and
// output register. When the rsp side stalls, the output register, the finish
// stage and the queue fill in turn and req_ready then drops; no item is lost.
// Synchronous reset returns the parser to the start of a literal and
// discards any queued characters and pending result.
`default_nettype none

module int128_literal_parser_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [ilp_pkg::CharWidth-1:0] req_char_code,
   input  wire logic                          req_last_char,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [ilp_pkg::WordWidth-1:0]      rsp_value_low,
   output logic [ilp_pkg::WordWidth-1:0]      rsp_value_high,
   output logic [ilp_pkg::StatusWidth-1:0]    rsp_status
);
   import ilp_pkg::*;

   logic    queue_full;
   logic    take;
   cmd_type front_cmd;
   logic    head_valid;
   cmd_type head_data;
   logic    pop;

   assign req_ready = !queue_full;
   assign take      = req_valid && !queue_full;

   ilp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .char_code (req_char_code),
      .last_char (req_last_char),
      .cmd       (front_cmd)
   );

   ilp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (take),
      .push_data  (front_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   ilp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_data      (head_data),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value_low  (rsp_value_low),
      .rsp_value_high (rsp_value_high),
      .rsp_status     (rsp_status)
   );

endmodule

`default_nettype wire

/* tb/int128_literal_parser_core_tb.sv */
`timescale 1ns / 1ps

module int128_literal_parser_core_tb;
   import ilp_pkg::*;

   typedef enum logic [2:0] {
      AT_START       = 3'd0,
      AFTER_SIGN     = 3'd1,
      AFTER_ZERO     = 3'd2,
      IN_DIGITS      = 3'd3,
      AFTER_HEX_MARK = 3'd4
   } parse_phase_type;

   typedef struct packed {
      logic [WordWidth-1:0] value_low;
      logic [WordWidth-1:0] value_high;
      status_type           status;
   } literal_result_type;

   localparam int unsigned IdleMax     = 14;
   localparam int unsigned StallLimit  = 2000;
   localparam int unsigned ItemTarget  = 1750;
   localparam int unsigned HoldCycles  = 300;
   localparam int unsigned DrainCycles = 20;
   localparam int unsigned PrintLimit  = 40;
   localparam logic [8*NullLength-1:0] Keyword = "nullptr";

   class literal_scoreboard;
      logic [AccWidth-1:0] acc;
      parse_phase_type     phase;
      logic                negative;
      radix_type           radix;
      status_type          fault;
      int unsigned         keyword_pos;
      bit                  keyword_alive;
      literal_result_type  pending_results[$];
      int unsigned         errors = 0;
      int unsigned         ok_count = 0;
      int unsigned         bad_digit_count = 0;
      int unsigned         lone_sign_count = 0;

      function new();
         clear_literal();
      endfunction

      function void clear_literal();
         acc = '0;
         phase = AT_START;
         negative = 1'b0;
         radix = RADIX_DEC;
         fault = STATUS_OK;
         keyword_pos = 0;
         keyword_alive = 1'b1;
      endfunction

      function int unsigned char_to_digit(logic [7:0] c);
         if (c >= "0" && c <= "9") return c - "0";
         if (c >= "a" && c <= "f") return c - "a" + 10;
         if (c >= "A" && c <= "F") return c - "A" + 10;
         return 255;
      endfunction

      // Once a fault is latched, the remaining characters leave the value alone.
      function void take_digit(logic [7:0] c);
         int unsigned base;
         int unsigned d;
         base = (radix == RADIX_HEX) ? 16 : (radix == RADIX_OCT) ? 8 : 10;
         d = char_to_digit(c);
         if (fault != STATUS_OK) return;
         if (d >= base) begin
            fault = STATUS_BAD_DIGIT;
            return;
         end
         acc = acc * AccWidth'(base) + AccWidth'(d);
      endfunction

      function void note_input(logic [7:0] c, logic last);
         logic [AccWidth-1:0] value;
         literal_result_type  res;
         if (keyword_alive && keyword_pos < NullLength &&
             c == Keyword[8*(NullLength-1-keyword_pos) +: 8])
            keyword_pos++;
         else
            keyword_alive = 1'b0;

         case (phase)
            AFTER_ZERO: begin
               if (c == "x" || c == "X") begin
                  radix = RADIX_HEX;
                  phase = AFTER_HEX_MARK;
               end else begin
                  radix = RADIX_OCT;
                  take_digit(c);
                  phase = IN_DIGITS;
               end
            end
            IN_DIGITS, AFTER_HEX_MARK: begin
               take_digit(c);
               phase = IN_DIGITS;
            end
            AFTER_SIGN: begin
               if (c == "0") begin
                  phase = AFTER_ZERO;
               end else begin
                  take_digit(c);
                  phase = IN_DIGITS;
               end
            end
            default: begin
               if (c == "+" || c == "-") begin
                  negative = (c == "-");
                  phase = AFTER_SIGN;
                  if (last) fault = STATUS_LONE_SIGN;
               end else if (c == "0") begin
                  phase = AFTER_ZERO;
               end else begin
                  take_digit(c);
                  phase = IN_DIGITS;
               end
            end
         endcase

         if (!last) return;
         res = '0;
         // The exact keyword wins over the bad digit its letters raised.
         if (keyword_alive && keyword_pos == NullLength) begin
            res.status = STATUS_OK;
         end else if (fault != STATUS_OK) begin
            res.status = fault;
         end else begin
            value = negative ? ~acc + 1'b1 : acc;
            res.value_low = value[WordWidth-1:0];
            res.value_high = value[AccWidth-1:WordWidth];
            res.status = STATUS_OK;
         end
         case (res.status)
            STATUS_OK:        ok_count++;
            STATUS_BAD_DIGIT: bad_digit_count++;
            default:          lone_sign_count++;
         endcase
         pending_results = {pending_results, res};
         clear_literal();
      endfunction

      function void report_field(string field, logic [63:0] expected, logic [63:0] actual);
         errors++;
         if (errors <= PrintLimit)
            $display("%0t: %s mismatch: expected %h, actual %h", $time, field, expected, actual);
      endfunction

      function void check_result(logic [63:0] low, logic [63:0] high, logic [1:0] status);
         literal_result_type want;
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: low %h high %h status %0d",
                     $time, low, high, status);
            return;
         end
         want = pending_results.pop_front();
         if (low !== want.value_low) report_field("value_low", want.value_low, low);
         if (high !== want.value_high) report_field("value_high", want.value_high, high);
         if (status !== want.status) report_field("status", 64'(want.status), 64'(status));
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [CharWidth-1:0]   req_char_code = '0;
   logic                   req_last_char = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [WordWidth-1:0]   rsp_value_low;
   logic [WordWidth-1:0]   rsp_value_high;
   logic [StatusWidth-1:0] rsp_status;

   literal_scoreboard sb = new;
   logic [7:0]        literal_text[$];
   int unsigned       chars_sent = 0;
   int unsigned       literals_sent = 0;
   int unsigned       sender_burst = 0;
   int unsigned       stall_cycles = 0;
   int unsigned       quiet_cycles = 0;

   int128_literal_parser_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_char_code  (req_char_code),
      .req_last_char  (req_last_char),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value_low  (rsp_value_low),
      .rsp_value_high (rsp_value_high),
      .rsp_status     (rsp_status)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_input(req_char_code, req_last_char);
         if (req_valid && !req_ready) stall_cycles++;
         if (rsp_valid && rsp_ready) sb.check_result(rsp_value_low, rsp_value_high, rsp_status);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == StallLimit) begin
         $display("%0t: no item moved for %0d cycles", $time, StallLimit);
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic logic [7:0] random_digit(radix_type r);
      int unsigned v;
      case (r)
         RADIX_OCT: v = $urandom_range(0, 7);
         RADIX_HEX: v = $urandom_range(0, 15);
         default:   v = $urandom_range(0, 9);
      endcase
      if (v < 10) return 8'("0" + v);
      return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
   endfunction

   task automatic queue_char(input logic [7:0] c);
      literal_text = {literal_text, c};
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) queue_char(s[i]);
   endtask

   task automatic send_char(input logic [7:0] code, input logic last);
      int unsigned gap;
      if (sender_burst > 0) begin
         gap = 0;
         sender_burst--;
      end else begin
         gap = $urandom_range(0, IdleMax);
         if ($urandom_range(0, 7) == 0) sender_burst = $urandom_range(5, 30);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_code <= code;
      req_last_char <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_literal();
      for (int i = 0; i < literal_text.size(); i++)
         send_char(literal_text[i], i == literal_text.size() - 1);
      chars_sent += literal_text.size();
      literals_sent++;
      literal_text.delete();
   endtask

   initial begin : receiver
      int unsigned gap;
      int unsigned burst_left;
      int unsigned taken;
      burst_left = 0;
      taken = 0;
      while (reset) @(posedge clock);
      forever begin
         // Two long holds let the parser fill up and push back on req.
         if (taken == 20 || taken == 90) begin
            gap = HoldCycles;
         end else if (burst_left > 0) begin
            gap = 0;
            burst_left--;
         end else begin
            gap = $urandom_range(0, IdleMax);
            if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(5, 30);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
      end
   end

   initial begin : stimulus
      int unsigned kind;
      int unsigned len;
      int unsigned pos;
      radix_type   radix_pick;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_text("nullptr");
      send_literal();
      add_text("0");
      send_literal();
      add_text("-0x");
      send_literal();
      add_text("+");
      send_literal();
      add_text("-");
      send_literal();
      add_text("017");
      send_literal();
      add_text("0Xf");
      send_literal();
      add_text("-9");
      send_literal();
      add_text("1-");
      send_literal();
      queue_char(8'h00);
      send_literal();
      queue_char(8'hFF);
      send_literal();

      while (chars_sent < ItemTarget) begin
         kind = $urandom_range(0, 99);
         if (kind < 75) begin
            radix_pick = radix_type'($urandom_range(0, 2));
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 45) : $urandom_range(1, 12);
            if ($urandom_range(0, 2) == 0)
               queue_char($urandom_range(0, 1) ? "-" : "+");
            case (radix_pick)
               RADIX_DEC: begin
                  queue_char(8'("1" + $urandom_range(0, 8)));
                  repeat (len - 1) queue_char(random_digit(RADIX_DEC));
               end
               RADIX_OCT: begin
                  queue_char("0");
                  repeat (len) queue_char(random_digit(RADIX_OCT));
               end
               default: begin
                  queue_char("0");
                  queue_char($urandom_range(0, 1) ? "x" : "X");
                  repeat (len - 1) queue_char(random_digit(RADIX_HEX));
               end
            endcase
            // A share of the well-formed literals gets one character spoiled.
            if (kind >= 60) begin
               pos = $urandom_range(0, literal_text.size() - 1);
               literal_text[pos] = $urandom_range(0, 1) ? "-" : 8'($urandom_range(0, 255));
            end
         end else if (kind < 87) begin
            case ($urandom_range(0, 9))
               0, 1: add_text("nullptr");
               2:    add_text("nul");
               3:    add_text("nullptrr");
               4:    add_text("nullpTr");
               5:    add_text("-nullptr");
               6:    add_text($urandom_range(0, 1) ? "-" : "+");
               7:    add_text("0");
               8:    add_text($urandom_range(0, 1) ? "-0X" : "0x");
               default: add_text($urandom_range(0, 1) ? "-0" : "+0");
            endcase
         end else begin
            repeat ($urandom_range(1, 6)) queue_char(8'($urandom_range(0, 255)));
         end
         send_literal();
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Covered %0d characters in %0d literals: %0d ok, %0d bad digit, %0d lone sign.",
               chars_sent, literals_sent, sb.ok_count, sb.bad_digit_count, sb.lone_sign_count);
      $display("Input was held off for %0d cycles in all, with two %0d-cycle result holds.",
               stall_cycles, HoldCycles);
      if (sb.errors == 0 && sb.pending_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches, %0d results never arrived",
                  sb.errors, sb.pending_results.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* int128_literal_parser_core.f */
rtl/ilp_pkg.sv
rtl/ilp_front.sv
rtl/ilp_queue.sv
rtl/ilp_back.sv
rtl/int128_literal_parser_core.sv
tb/int128_literal_parser_core_tb.sv
